@@ src/cst_pkg.sv @@
// Shared types and constants of the CSV stream tokenizer.
package cst_pkg;

	// Characters that steer the parser.
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_NL    = 8'h0A;

	// Parser modes; MODE_ERROR holds the sticky error until reset.
	typedef enum logic [2:0] {
		MODE_START,
		MODE_PLAIN,
		MODE_QUOTED,
		MODE_QSEEN,
		MODE_ERROR
	} mode_t;

	// Token kinds.
	typedef enum logic [1:0] {
		KIND_DATA,
		KIND_FIELD_END,
		KIND_ROW_END,
		KIND_ERROR
	} kind_t;

	// Error codes.
	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_STRAY_QUOTE,
		ERR_AFTER_QUOTE,
		ERR_TOO_MANY
	} err_t;

	// Input word.
	typedef struct packed {
		logic [7:0] in_byte;
	} text_word_t;

	// Output word.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		err_t        error_code;
		logic [9:0]  field_index;
		logic [31:0] row_index;
	} token_word_t;

	// Result of one parser step, passed from the parser core to the top level.
	typedef struct packed {
		logic       emit;
		kind_t      kind;
		logic [7:0] data_byte;
		err_t       error_code;
	} step_res_t;

endpackage

@@ src/cst_stream_if.sv @@
// Valid/ready stream channel carrying one word per handshake.
interface cst_stream_if #(
	parameter type data_t = logic [7:0]
) ();
	logic  valid;
	logic  ready;
	data_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ src/csv_stream_tokenizer.sv @@
// An accepted byte waits in the input register until the output register is free, then its token is registered there.
// Throughput: one byte per clock; the input register, the parser step and the
// output register each take a word every cycle while the sink keeps up.
// Bytes that produce no token (an opening quote, a first closing quote, any byte
// after an error) leave the pipeline silently.
// Reset (arst_n low) empties the pipeline and returns the parser to field start.
module csv_stream_tokenizer #(
	parameter int MAX_COLUMNS = 1024
) (
	input logic         clk,
	input logic         arst_n,
	cst_stream_if.sink   text,
	cst_stream_if.source token
);
	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  out_valid_q;
	cst_pkg::token_word_t  out_q;
	logic                  advance;
	logic                  step;
	cst_pkg::step_res_t    res;
	logic [9:0]            field_index;
	logic [31:0]           row_index;

	// The output register frees up when empty or taken this cycle.
	assign advance    = !out_valid_q || token.ready;
	assign step       = valid_s1 && advance;
	assign text.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.data.in_byte;
		end
	end

	cst_fsm #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.cur_byte   (byte_s1),
		.res        (res),
		.field_index(field_index),
		.row_index  (row_index)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.emit) begin
			out_q.kind        <= res.kind;
			out_q.data_byte   <= res.data_byte;
			out_q.error_code  <= res.error_code;
			out_q.field_index <= field_index;
			out_q.row_index   <= row_index;
		end
	end

	assign token.valid = out_valid_q;
	assign token.data  = out_q;

endmodule

@@ src/cst_fsm.sv @@
// Parser core: mode state machine, field and row counters, and token decode.
module cst_fsm #(
	parameter int MAX_COLUMNS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            cur_byte,
	output cst_pkg::step_res_t    res,
	output logic [9:0]            field_index,
	output logic [31:0]           row_index
);
	localparam int CW = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;
	localparam int FW = (CW > 10) ? CW : 10;
	localparam logic [CW:0] MAX_C = (CW + 1)'(MAX_COLUMNS);

	cst_pkg::mode_t mode_q, mode_d;
	logic [CW-1:0]  fc_q, fc_d;
	logic [CW:0]    exp_q, exp_d;
	logic [31:0]    row_q, row_d;
	logic [CW:0]    fc_next;
	logic [FW-1:0]  fc_ext;
	logic           is_quote, is_comma, is_nl;
	logic           too_many;

	// Character classes and the field count that a comma would open.
	assign is_quote = (cur_byte == cst_pkg::CH_QUOTE);
	assign is_comma = (cur_byte == cst_pkg::CH_COMMA);
	assign is_nl    = (cur_byte == cst_pkg::CH_NL);
	assign fc_next  = {1'b0, fc_q} + (CW + 1)'(1);
	assign too_many = (fc_next >= MAX_C) || ((exp_q != '0) && (fc_next >= exp_q));

	// Counters as seen by the current token, before this byte updates them.
	assign fc_ext      = FW'(fc_q);
	assign field_index = fc_ext[9:0];
	assign row_index   = row_q;

	// State register and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= cst_pkg::MODE_START;
			fc_q   <= '0;
			exp_q  <= '0;
			row_q  <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			fc_q   <= fc_d;
			exp_q  <= exp_d;
			row_q  <= row_d;
		end
	end

	// Next state and token for the current byte.
	always_comb begin
		mode_d         = mode_q;
		fc_d           = fc_q;
		exp_d          = exp_q;
		row_d          = row_q;
		res.emit       = 1'b0;
		res.kind       = cst_pkg::KIND_DATA;
		res.data_byte  = '0;
		res.error_code = cst_pkg::ERR_NONE;
		unique case (mode_q)
			cst_pkg::MODE_START, cst_pkg::MODE_PLAIN, cst_pkg::MODE_QSEEN: begin
				if (is_quote) begin
					if (mode_q == cst_pkg::MODE_START) begin
						mode_d = cst_pkg::MODE_QUOTED;
					end else if (mode_q == cst_pkg::MODE_QSEEN) begin
						// A doubled quote stands for one quote byte.
						res.emit      = 1'b1;
						res.data_byte = cur_byte;
						mode_d        = cst_pkg::MODE_QUOTED;
					end else begin
						res.emit       = 1'b1;
						res.kind       = cst_pkg::KIND_ERROR;
						res.error_code = cst_pkg::ERR_STRAY_QUOTE;
						mode_d         = cst_pkg::MODE_ERROR;
					end
				end else if (is_comma) begin
					res.emit = 1'b1;
					if (too_many) begin
						res.kind       = cst_pkg::KIND_ERROR;
						res.error_code = cst_pkg::ERR_TOO_MANY;
						mode_d         = cst_pkg::MODE_ERROR;
					end else begin
						res.kind = cst_pkg::KIND_FIELD_END;
						fc_d     = fc_next[CW-1:0];
						mode_d   = cst_pkg::MODE_START;
					end
				end else if (is_nl) begin
					// The first finished row fixes the column count.
					res.emit = 1'b1;
					res.kind = cst_pkg::KIND_ROW_END;
					if (exp_q == '0) begin
						exp_d = fc_next;
					end
					fc_d = '0;
					if (row_q != '1) begin
						row_d = row_q + 32'd1;
					end
					mode_d = cst_pkg::MODE_START;
				end else if (mode_q == cst_pkg::MODE_QSEEN) begin
					res.emit       = 1'b1;
					res.kind       = cst_pkg::KIND_ERROR;
					res.error_code = cst_pkg::ERR_AFTER_QUOTE;
					mode_d         = cst_pkg::MODE_ERROR;
				end else begin
					res.emit      = 1'b1;
					res.data_byte = cur_byte;
					mode_d        = cst_pkg::MODE_PLAIN;
				end
			end
			cst_pkg::MODE_QUOTED: begin
				if (is_quote) begin
					mode_d = cst_pkg::MODE_QSEEN;
				end else begin
					res.emit      = 1'b1;
					res.data_byte = cur_byte;
				end
			end
			cst_pkg::MODE_ERROR: begin
				mode_d = cst_pkg::MODE_ERROR;
			end
			default: begin
				mode_d = cst_pkg::MODE_ERROR;
			end
		endcase
	end

endmodule

@@ src/cst_checker.sv @@
// Port-level checks of the CSV stream tokenizer, bound to its top level.
module cst_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input cst_pkg::token_word_t out_data
);

	// A stalled word holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("token word changed while stalled");

	// Only error words carry an error code, and they always carry one.
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.kind == cst_pkg::KIND_ERROR) ==
			(out_data.error_code != cst_pkg::ERR_NONE)))
		else $error("error code does not match token kind");

	// Marks and errors carry no content byte.
	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind != cst_pkg::KIND_DATA |-> out_data.data_byte == 8'd0)
		else $error("content byte set on a non-content word");

	// Errors are sticky: nothing follows a taken error word.
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.kind == cst_pkg::KIND_ERROR |=> !out_valid)
		else $error("word emitted after an error");

endmodule

bind csv_stream_tokenizer cst_checker u_cst_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(token.valid),
	.out_ready(token.ready),
	.out_data (token.data)
);
